### design/lru_frame_replacer_unit_defines.svh
// ----------------------------------------------------------------------------
// LRU frame replacer assertion macros
// Shared property forms for the replacer checks.
// ----------------------------------------------------------------------------
`ifndef LRU_FRAME_REPLACER_UNIT_DEFINES_SVH
`define LRU_FRAME_REPLACER_UNIT_DEFINES_SVH

// same-cycle implication
`define LRUFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRUFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lrufr_pkg.sv
// ----------------------------------------------------------------------------
// LRU frame replacer package
// Widths, operation codes and the cell control bundle.
// ----------------------------------------------------------------------------
package lrufr_pkg;

  localparam int FRAME_W            = 6;
  localparam int COUNT_W            = 7;
  localparam int FRAME_IDS          = 64;
  localparam int DEFAULT_MAX_FRAMES = 64;
  localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_VICTIM = 2'd0,
    OP_PIN    = 2'd1,
    OP_UNPIN  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    logic               shift_en;
    logic               write_en;
    logic [FRAME_W-1:0] frame;
  } cell_ctl_t;

endpackage

### design/lrufr_cell.sv
// ----------------------------------------------------------------------------
// LRU frame replacer cell
// One recency slot: closes toward the head on removal, loads on insert.
// ----------------------------------------------------------------------------
module lrufr_cell
  import lrufr_pkg::*;
#(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctl_t          ctl,
  input  logic [IDX_W-1:0]   shift_pos,
  input  logic [IDX_W-1:0]   wr_pos,
  input  logic               nbr_valid,
  input  logic [FRAME_W-1:0] nbr_frame,
  output logic               valid,
  output logic [FRAME_W-1:0] frame,
  output logic               match
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic               valid_r, valid_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               take_nbr;

  assign take_nbr = ctl.shift_en && (MY_IDX >= shift_pos);

  always_comb begin
    valid_nxt = valid_r;
    frame_nxt = frame_r;
    if (take_nbr) begin
      valid_nxt = nbr_valid;
      frame_nxt = nbr_frame;
    end else if (ctl.write_en && (MY_IDX == wr_pos)) begin
      valid_nxt = 1'b1;
      frame_nxt = ctl.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

  assign valid = valid_r;
  assign frame = frame_r;
  assign match = valid_r && (frame_r == ctl.frame);

endmodule

### design/lrufr_pos_enc.sv
// ----------------------------------------------------------------------------
// LRU frame replacer position encoder
// Turns the one-hot cell match vector into a slot index.
// ----------------------------------------------------------------------------
module lrufr_pos_enc
  import lrufr_pkg::*;
#(
  parameter int MAX_FRAMES = DEFAULT_MAX_FRAMES,
  parameter int IDX_W      = 6
) (
  input  logic [MAX_FRAMES-1:0] match,
  output logic [IDX_W-1:0]      pos
);

  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (match[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

endmodule

### design/lru_frame_replacer_unit.sv
// ----------------------------------------------------------------------------
// LRU frame replacer unit
// Recency-ordered set of evictable frames held in a chain of slot cells.
// ----------------------------------------------------------------------------
// Takes one operation per clock (busy stays low); the result strobes on
// out_valid exactly one cycle after the transfer and must be taken then,
// since the receiver cannot stall. Every operation, pin included, finishes
// in that one cycle: all cells compare against the frame at once, an
// encoder turns the single hit into a slot index, and every slot at or
// beyond it loads its neighbor in the same clock. The membership map and
// the slot valid bits clear at reset; no clearing pass is needed.
`include "lru_frame_replacer_unit_defines.svh"

module lru_frame_replacer_unit
  import lrufr_pkg::*;
#(
  parameter int MAX_FRAMES = DEFAULT_MAX_FRAMES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [FRAME_W-1:0] in_frame,
  output logic               out_valid,
  output logic               out_found,
  output logic [FRAME_W-1:0] out_victim_frame,
  output logic [COUNT_W-1:0] out_count,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_FRAMES);

  logic [COUNT_W-1:0]   cap_r;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [FRAME_IDS-1:0] present_r, present_nxt;

  logic                 out_valid_r;
  logic                 out_found_r, out_found_nxt;
  logic [FRAME_W-1:0]   out_victim_r, out_victim_nxt;

  logic                 accept;
  op_t                  op;
  cell_ctl_t            ctl;
  logic [IDX_W-1:0]     shift_pos, wr_pos, hit_pos;

  logic [MAX_FRAMES-1:0] cell_valid;
  logic [FRAME_W-1:0]    cell_frame [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] cell_match;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = op_t'(in_op);
  assign wr_pos = IDX_W'(count_r);

  lrufr_pos_enc #(
    .MAX_FRAMES(MAX_FRAMES),
    .IDX_W     (IDX_W)
  ) u_pos_enc (
    .match(cell_match),
    .pos  (hit_pos)
  );

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    logic               nbr_valid;
    logic [FRAME_W-1:0] nbr_frame;
    if (g == MAX_FRAMES - 1) begin : g_tail
      assign nbr_valid = 1'b0;
      assign nbr_frame = '0;
    end else begin : g_body
      assign nbr_valid = cell_valid[g+1];
      assign nbr_frame = cell_frame[g+1];
    end
    lrufr_cell #(
      .IDX_W   (IDX_W),
      .CELL_IDX(g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .shift_pos(shift_pos),
      .wr_pos   (wr_pos),
      .nbr_valid(nbr_valid),
      .nbr_frame(nbr_frame),
      .valid    (cell_valid[g]),
      .frame    (cell_frame[g]),
      .match    (cell_match[g])
    );
  end

  always_comb begin
    ctl.shift_en   = 1'b0;
    ctl.write_en   = 1'b0;
    ctl.frame      = in_frame;
    shift_pos      = hit_pos;
    count_nxt      = count_r;
    present_nxt    = present_r;
    out_found_nxt  = 1'b0;
    out_victim_nxt = '0;
    if (accept) begin
      unique case (op)
        OP_VICTIM: begin
          shift_pos = '0;
          if (count_r != '0) begin
            ctl.shift_en                = 1'b1;
            out_found_nxt               = 1'b1;
            out_victim_nxt              = cell_frame[0];
            present_nxt[cell_frame[0]]  = 1'b0;
            count_nxt                   = count_r - COUNT_W'(1);
          end
        end
        OP_PIN: begin
          if (present_r[in_frame]) begin
            ctl.shift_en          = 1'b1;
            present_nxt[in_frame] = 1'b0;
            count_nxt             = count_r - COUNT_W'(1);
          end
        end
        OP_UNPIN: begin
          if (!present_r[in_frame] && (count_r < cap_r) &&
              (int'(count_r) < MAX_FRAMES)) begin
            ctl.write_en          = 1'b1;
            present_nxt[in_frame] = 1'b1;
            count_nxt             = count_r + COUNT_W'(1);
          end
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      count_r     <= count_nxt;
      present_r   <= present_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_found_r  <= out_found_nxt;
      out_victim_r <= out_victim_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_victim_frame = out_victim_r;
  assign out_count        = count_r;

  `LRUFR_ASSERT_NOW(a_count_tracks_map, 1'b1, int'(count_r) == $countones(present_r), "entry count out of step with membership map")
  `LRUFR_ASSERT_NOW(a_single_hit, 1'b1, $countones(cell_match) <= 1, "frame held in more than one slot")
  `LRUFR_ASSERT_NEXT(a_result_follows, accept, out_valid, "accepted operation gave no result")
  `LRUFR_ASSERT_NOW(a_victim_zero, out_valid && !out_found, out_victim_frame == '0, "victim frame nonzero without a hit")

endmodule
